// ===== hw/rtl/kbft_pkg.sv =====
// Shared constants, codes and types of the key and button frame tracker.
package kbft_pkg;

   localparam int KEY_ENTRIES    = 512;
   localparam int BUTTON_ENTRIES = 8;
   localparam int STAMP_BITS     = 32;
   localparam int QUEUE_DEPTH    = 2;

   localparam int KEY_ADDR_W = $clog2(KEY_ENTRIES);
   localparam int BTN_ADDR_W = $clog2(BUTTON_ENTRIES);
   localparam int QPTR_W     = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

   localparam int INDEX_W  = 9;
   localparam int OP_W     = 3;
   localparam int ACTION_W = 2;
   localparam int COUNT_W  = 8;
   localparam int MODS_W   = 8;

   localparam int REQ_DATA_W = 32;
   localparam int RSP_DATA_W = 40;

   localparam logic [OP_W-1:0] OP_KEY_EVENT = 3'd0;
   localparam logic [OP_W-1:0] OP_BTN_EVENT = 3'd1;
   localparam logic [OP_W-1:0] OP_MODS      = 3'd2;
   localparam logic [OP_W-1:0] OP_TICK      = 3'd3;
   localparam logic [OP_W-1:0] OP_KEY_READ  = 3'd4;
   localparam logic [OP_W-1:0] OP_BTN_READ  = 3'd5;

   localparam logic [ACTION_W-1:0] ACT_PRESS   = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_REPEAT  = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_RELEASE = 2'd2;

   localparam logic [COUNT_W-1:0] COUNT_MAX = 8'hFF;

   typedef struct packed {
      logic                  down;
      logic [COUNT_W-1:0]    trans;
      logic [COUNT_W-1:0]    reps;
      logic                  clicked;
      logic                  dclicked;
      logic [STAMP_BITS-1:0] stamp;
   } kbft_entry_type;

   localparam int ENTRY_W = $bits(kbft_entry_type);

   typedef struct packed {
      logic [OP_W-1:0]     op;
      logic                hit;
      logic [INDEX_W-1:0]  index;
      logic [ACTION_W-1:0] action;
      logic                click_once;
      logic                click_twice;
      logic [MODS_W-1:0]   mods;
   } kbft_cmd_type;

   typedef struct packed {
      logic clearing;
   } kbft_status_type;

endpackage

// ===== hw/rtl/kbft_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module kbft_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata <= mem[raddr];
      end
   end

endmodule

// ===== hw/rtl/kbft_front.sv =====
// Front end: accepts request transactions, classifies them and queues commands.
module kbft_front (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [kbft_pkg::REQ_DATA_W-1:0]    req_tdata,
   input  logic [kbft_pkg::OP_W-1:0]          req_tuser,
   input  kbft_pkg::kbft_status_type          status,
   output logic                               cmd_valid,
   input  logic                               cmd_ready,
   output kbft_pkg::kbft_cmd_type             cmd
);
   import kbft_pkg::*;

   kbft_cmd_type          q_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]       count_ff, count_in;
   kbft_cmd_type          new_cmd;
   logic [INDEX_W-1:0]    idx;
   logic [COUNT_W-1:0]    clicks;
   logic                  push;
   logic                  pop;

   assign idx    = req_tdata[INDEX_W-1:0];
   assign clicks = req_tdata[INDEX_W+ACTION_W +: COUNT_W];

   always_comb begin
      new_cmd             = '0;
      new_cmd.op          = req_tuser;
      new_cmd.index       = idx;
      new_cmd.action      = req_tdata[INDEX_W +: ACTION_W];
      new_cmd.mods        = req_tdata[INDEX_W+ACTION_W+COUNT_W +: MODS_W];
      new_cmd.click_once  = (clicks >= COUNT_W'(1));
      new_cmd.click_twice = (clicks >= COUNT_W'(2));
      case (req_tuser)
         OP_KEY_EVENT, OP_KEY_READ: new_cmd.hit = (32'(idx) < KEY_ENTRIES);
         OP_BTN_EVENT, OP_BTN_READ: new_cmd.hit = (32'(idx) < BUTTON_ENTRIES);
         default:                   new_cmd.hit = 1'b0;
      endcase
   end

   assign req_tready = !status.clearing && (count_ff != (QPTR_W+1)'(QUEUE_DEPTH));
   assign push       = req_tvalid && req_tready;
   assign cmd_valid  = (count_ff != '0);
   assign pop        = cmd_valid && cmd_ready;
   assign cmd        = q_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH-1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH-1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         q_ff[wr_ptr_ff] <= new_cmd;
      end
   end

endmodule

// ===== hw/rtl/kbft_back.sv =====
// Back end: holds the entry tables and frame state, executes commands and drives responses.
module kbft_back (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               cmd_valid,
   output logic                               cmd_ready,
   input  kbft_pkg::kbft_cmd_type             cmd,
   output kbft_pkg::kbft_status_type          status,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [kbft_pkg::RSP_DATA_W-1:0]    rsp_tdata
);
   import kbft_pkg::*;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_EXEC
   } state_type;

   state_type               state_ff;
   logic [KEY_ADDR_W-1:0]   clr_cnt_ff;
   logic [STAMP_BITS-1:0]   frame_ff, frame_in;
   logic [MODS_W-1:0]       mods_ff, mods_in;
   kbft_entry_type          btn_ff [BUTTON_ENTRIES];
   kbft_cmd_type            cmd_ff;
   logic                    rsp_valid_ff;
   logic [RSP_DATA_W-1:0]   rsp_data_ff, rsp_data_in;

   logic                    ram_we;
   logic [KEY_ADDR_W-1:0]   ram_waddr;
   logic [ENTRY_W-1:0]      ram_wdata;
   logic                    ram_re;
   logic [ENTRY_W-1:0]      ram_rdata;

   kbft_entry_type          cur;
   kbft_entry_type          upd;
   kbft_entry_type          shown;
   logic                    is_btn;
   logic                    is_event;
   logic                    out_free;
   logic                    finish;
   logic                    fresh;
   logic [COUNT_W-1:0]      half;
   logic                    odd;
   logic                    r_down;
   logic [COUNT_W-1:0]      r_press;
   logic [COUNT_W-1:0]      r_release;
   logic [COUNT_W-1:0]      r_repeat;
   logic                    r_clicked;
   logic                    r_dclicked;

   kbft_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (KEY_ENTRIES)
   ) u_key_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (ram_re),
      .raddr (KEY_ADDR_W'(cmd.index)),
      .rdata (ram_rdata)
   );

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign finish     = (state_ff == ST_EXEC) && out_free;
   assign cmd_ready  = (state_ff == ST_IDLE);
   assign ram_re     = cmd_valid && cmd_ready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   assign status.clearing = (state_ff == ST_CLEAR);

   assign is_btn   = (cmd_ff.op == OP_BTN_EVENT) || (cmd_ff.op == OP_BTN_READ);
   assign is_event = (cmd_ff.op == OP_KEY_EVENT) || (cmd_ff.op == OP_BTN_EVENT);
   assign cur      = is_btn ? btn_ff[BTN_ADDR_W'(cmd_ff.index)] : kbft_entry_type'(ram_rdata);

   always_comb begin
      upd = cur;
      if (cur.stamp != frame_ff) begin
         upd.trans    = '0;
         upd.reps     = '0;
         upd.clicked  = 1'b0;
         upd.dclicked = 1'b0;
         upd.stamp    = frame_ff;
      end
      case (cmd_ff.action)
         ACT_PRESS: begin
            if (!upd.down && upd.trans != COUNT_MAX) begin
               upd.trans = upd.trans + 1'b1;
            end
            upd.down = 1'b1;
         end
         ACT_REPEAT: begin
            if (upd.reps != COUNT_MAX) begin
               upd.reps = upd.reps + 1'b1;
            end
            upd.down = 1'b1;
         end
         ACT_RELEASE: begin
            if (upd.down && upd.trans != COUNT_MAX) begin
               upd.trans = upd.trans + 1'b1;
            end
            upd.down = 1'b0;
         end
         default: begin
         end
      endcase
      if (cmd_ff.op == OP_BTN_EVENT && cmd_ff.action == ACT_PRESS) begin
         upd.clicked  = upd.clicked || cmd_ff.click_once;
         upd.dclicked = upd.dclicked || cmd_ff.click_twice;
      end
   end

   always_comb begin
      shown      = is_event ? upd : cur;
      fresh      = (shown.stamp == frame_ff);
      half       = {1'b0, shown.trans[COUNT_W-1:1]};
      odd        = shown.trans[0];
      r_down     = cmd_ff.hit && shown.down;
      r_press    = '0;
      r_release  = '0;
      r_repeat   = '0;
      r_clicked  = 1'b0;
      r_dclicked = 1'b0;
      if (cmd_ff.hit && fresh) begin
         r_press    = half + COUNT_W'(shown.down & odd);
         r_release  = half + COUNT_W'(!shown.down & odd);
         r_repeat   = shown.reps;
         r_clicked  = shown.clicked;
         r_dclicked = shown.dclicked;
      end
      mods_in  = (is_event || cmd_ff.op == OP_MODS) ? cmd_ff.mods : mods_ff;
      frame_in = (cmd_ff.op == OP_TICK) ? frame_ff + 1'b1 : frame_ff;
      rsp_data_in = RSP_DATA_W'({mods_in, r_dclicked, r_clicked, r_repeat,
                                 r_release, r_press, r_down, cmd_ff.hit});
   end

   always_comb begin
      ram_we    = 1'b0;
      ram_waddr = KEY_ADDR_W'(cmd_ff.index);
      ram_wdata = upd;
      if (state_ff == ST_CLEAR) begin
         ram_we    = 1'b1;
         ram_waddr = clr_cnt_ff;
         ram_wdata = '0;
      end else if (finish && cmd_ff.op == OP_KEY_EVENT && cmd_ff.hit) begin
         ram_we = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_cnt_ff   <= '0;
         frame_ff     <= '0;
         mods_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < BUTTON_ENTRIES; i++) begin
            btn_ff[i] <= '0;
         end
      end else begin
         if (rsp_valid_ff && rsp_tready && !finish) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_CLEAR: begin
               clr_cnt_ff <= clr_cnt_ff + 1'b1;
               if (clr_cnt_ff == KEY_ADDR_W'(KEY_ENTRIES-1)) begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_IDLE: begin
               if (cmd_valid) begin
                  cmd_ff   <= cmd;
                  state_ff <= ST_EXEC;
               end
            end
            ST_EXEC: begin
               if (out_free) begin
                  frame_ff     <= frame_in;
                  mods_ff      <= mods_in;
                  rsp_valid_ff <= 1'b1;
                  rsp_data_ff  <= rsp_data_in;
                  if (cmd_ff.op == OP_BTN_EVENT && cmd_ff.hit) begin
                     btn_ff[BTN_ADDR_W'(cmd_ff.index)] <= upd;
                  end
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

endmodule

// ===== hw/rtl/key_button_frame_tracker.sv =====
// Top level of the key and button frame tracker: front end, command queue and back end.
//
//  channel | direction | tdata fields (lowest bit first)                        | tuser
//  req     | in        | entry_index, key_action, click_count, modifier_bits    | op
//  rsp     | out       | index_valid, is_down, press_count, release_count,      | none
//          |           | repeat_count, was_clicked, was_double_clicked,         |
//          |           | modifiers_now                                          |
//
// In the back end each transaction first reads the key RAM in ST_IDLE, then does the
// update, write-back and response register load in ST_EXEC.
// After reset all 512 key RAM entries are cleared one by one, during which req_tready is low.
// The front queue holds two commands, so requests are still taken while a response waits.
// A stalled response holds the back end, which then holds the queue.
module key_button_frame_tracker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // entry_index[8:0], key_action[10:9], click_count[18:11], modifier_bits[26:19]
   input  logic [kbft_pkg::REQ_DATA_W-1:0] req_tdata,
   // op[2:0]
   input  logic [kbft_pkg::OP_W-1:0]       req_tuser,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // index_valid[0], is_down[1], press_count[9:2], release_count[17:10],
   // repeat_count[25:18], was_clicked[26], was_double_clicked[27], modifiers_now[35:28]
   output logic [kbft_pkg::RSP_DATA_W-1:0] rsp_tdata
);
   import kbft_pkg::*;

   kbft_cmd_type    cmd;
   kbft_status_type status;
   logic            cmd_valid;
   logic            cmd_ready;

   kbft_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .status     (status),
      .cmd_valid  (cmd_valid),
      .cmd_ready  (cmd_ready),
      .cmd        (cmd)
   );

   kbft_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cmd_valid  (cmd_valid),
      .cmd_ready  (cmd_ready),
      .cmd        (cmd),
      .status     (status),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

// ===== hw/rtl/kbft_checker.sv =====
// Port-level checker for the key and button frame tracker, bound to the top level.
module kbft_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tvalid,
   input logic                            req_tready,
   input logic [kbft_pkg::REQ_DATA_W-1:0] req_tdata,
   input logic [kbft_pkg::OP_W-1:0]       req_tuser,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [kbft_pkg::RSP_DATA_W-1:0] rsp_tdata
);
   import kbft_pkg::*;

   logic req_seen;

   assign req_seen = req_tvalid && (req_tdata != '0 || req_tuser != '0 || 1'b1);

   // A stalled response transaction keeps its payload.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response changed while stalled");

   // The key table is being cleared straight after reset, so no request is taken.
   assert property (@(posedge clock) reset |=> !req_tready)
      else $error("request taken during key table clearing");

   // Nothing is answered straight after reset.
   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("response valid after reset");

   // Without an addressed entry every entry field of the response is zero.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[0] |-> rsp_tdata[27:1] == '0)
      else $error("entry fields set without a valid index");

   // A double click is always also a click.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[27] |-> rsp_tdata[26] || !req_seen && rsp_tdata[26])
      else $error("double click reported without click");

endmodule

bind key_button_frame_tracker kbft_checker u_kbft_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
